// ===== hdl/tstv_pkg.sv =====
package tstv_pkg;

  localparam int SideChannels   = 64;
  localparam int AddrW          = $clog2(SideChannels);
  localparam int CntW           = AddrW + 1;
  localparam int TimeW          = 16;
  localparam int SumW           = 23;
  localparam int ChargeW        = 20;
  localparam int AccW           = 27;
  localparam int CentralityBins = 20;
  localparam int BinW           = 5;
  localparam int VertexW        = 18;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 20;
  localparam int ProdW          = SumW + CntW + 1;
  localparam int DenW           = 2 * CntW;
  localparam int DivW           = 40;
  localparam int DivisorW       = DenW + 5;
  localparam int DivCntW        = $clog2(DivW);

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SIGMA     = 3'd2,
    REG_MIN_HITS  = 3'd3,
    REG_SHIFT     = 3'd4
  } reg_idx_e;

  function automatic logic [10:0] bound_rom(input int idx);
    logic [10:0] v;
    case (idx)
      0:       v = 11'd1999;
      1:       v = 11'd1499;
      2:       v = 11'd1291;
      3:       v = 11'd1102;
      4:       v = 11'd937;
      5:       v = 11'd790;
      6:       v = 11'd660;
      7:       v = 11'd547;
      8:       v = 11'd449;
      9:       v = 11'd363;
      10:      v = 11'd289;
      11:      v = 11'd227;
      12:      v = 11'd174;
      13:      v = 11'd130;
      14:      v = 11'd94;
      15:      v = 11'd66;
      16:      v = 11'd45;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

  function automatic logic [BinW-1:0] centrality(input logic [AccW-1:0] acc);
    logic [BinW-1:0] bin;
    logic            found;
    bin   = BinW'(CentralityBins - 1);
    found = 1'b0;
    for (int b = 0; b < CentralityBins - 1; b++) begin
      if (!found && (acc > (AccW'(bound_rom(b + 1)) << 8))) begin
        bin   = BinW'(b);
        found = 1'b1;
      end
    end
    return bin;
  endfunction

  function automatic logic signed [VertexW-1:0] sat_vertex(input logic signed [DivW:0] v);
    logic signed [VertexW-1:0] r;
    if (v > 41'sd131071) begin
      r = 18'sd131071;
    end else if (v < -41'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = signed'(v[VertexW-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [TimeW-1:0] sat_time(input logic signed [DivW:0] v);
    logic signed [TimeW-1:0] r;
    if (v > 41'sd32767) begin
      r = 16'sd32767;
    end else if (v < -41'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = signed'(v[TimeW-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== hdl/two_sided_timing_vertex.sv =====
// Collects one event as a stream of channel items, one item per cycle with no stall, storing
// hit times in a south and a north time memory. After the last item the input stalls while
// the event is finished: a setup step, a median selection pass (skipped when either side
// has fewer than two hits), a window pass over the larger side hit count (no reads when
// both sides are empty), a multiply step and four serial divisions, then the output
// register is loaded once it is free. The median pass, which compares every stored time
// against every other through the single read port of each time memory, takes longest
// for full sides. The output register lets the result wait while the next event is
// collected.
module two_sided_timing_vertex (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [tstv_pkg::CntW-1:0]              channel_i,
  input  logic [tstv_pkg::ChargeW-1:0]           charge_i,
  input  logic signed [tstv_pkg::TimeW-1:0]      hit_time_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   pair_valid_o,
  output logic signed [tstv_pkg::VertexW-1:0]    mean_vertex_o,
  output logic signed [tstv_pkg::TimeW-1:0]      event_time_mean_o,
  output logic signed [tstv_pkg::VertexW-1:0]    median_vertex_o,
  output logic signed [tstv_pkg::TimeW-1:0]      event_time_median_o,
  output logic                                   center_valid_o,
  output logic signed [tstv_pkg::VertexW-1:0]    vertex_by_center_o,
  output logic signed [tstv_pkg::TimeW-1:0]      event_time_center_o,
  output logic [tstv_pkg::CntW-1:0]              south_hits_o,
  output logic [tstv_pkg::CntW-1:0]              north_hits_o,
  output logic [tstv_pkg::AccW-1:0]              charge_total_o,
  output logic [tstv_pkg::BinW-1:0]              cent_class_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tstv_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [tstv_pkg::CfgDataW-1:0]          cfg_data_i
);

  localparam int CntW = tstv_pkg::CntW;
  localparam int TW   = tstv_pkg::TimeW;
  localparam int SW   = tstv_pkg::SumW;
  localparam int DW   = tstv_pkg::DivW;
  localparam int BW   = tstv_pkg::DivisorW;

  typedef enum logic [2:0] {
    ST_ACC, ST_START, ST_MED, ST_WIN, ST_MUL, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  logic [tstv_pkg::ChargeW-1:0] thr_q;
  logic signed [TW-1:0]         offs_q;
  logic [TW-1:0]                sigma_q;
  logic [CntW-1:0]              minh_q;
  logic signed [TW-1:0]         vshift_q;

  logic signed [TW-1:0] s_mem [tstv_pkg::SideChannels];
  logic signed [TW-1:0] n_mem [tstv_pkg::SideChannels];
  logic signed [TW-1:0] s_rd_q, n_rd_q;

  logic signed [SW-1:0]          s_sum_q, n_sum_q;
  logic [CntW-1:0]               s_cnt_q, n_cnt_q;
  logic [tstv_pkg::AccW-1:0]     acc_q;

  logic                          iss_done_q, ph_q;
  logic [CntW-1:0]               j_q, k_q;
  logic                          rd_vld_q, rd_cand_q, rd_end_q;
  logic [CntW-1:0]               rd_idx_q;

  logic signed [TW-1:0]          cand_s_q, cand_n_q;
  logic [CntW-1:0]               cand_j_q;
  logic [CntW-1:0]               lt_s_q, le_s_q, lt_n_q, le_n_q;
  logic signed [TW-1:0]          vlo_s_q, vhi_s_q, vlo_n_q, vhi_n_q;

  logic signed [SW-1:0]          wsum_s_q, wsum_n_q;
  logic [CntW-1:0]               wcnt_s_q, wcnt_n_q;

  logic signed [tstv_pkg::ProdW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic [tstv_pkg::DenW-1:0]         den1_q, den2_q;

  logic                          div_busy_q, neg_q;
  logic [1:0]                    op_q;
  logic [tstv_pkg::DivCntW-1:0]  div_cnt_q;
  logic [DW-1:0]                 dq_q;
  logic [BW-1:0]                 rem_q, b_q;

  logic signed [TW-1:0]               tm_q, tc_q;
  logic signed [tstv_pkg::VertexW-1:0] vm_q, vc_q;

  logic                                out_valid_q;
  logic                                pair_q, center_q;
  logic signed [tstv_pkg::VertexW-1:0] o_vm_q, o_vmed_q, o_vc_q;
  logic signed [TW-1:0]                o_tm_q, o_tmed_q, o_tc_q;
  logic [CntW-1:0]                     o_s_q, o_n_q;
  logic [tstv_pkg::AccW-1:0]           o_acc_q;
  logic [tstv_pkg::BinW-1:0]           o_bin_q;

  // input side
  logic                          in_acc, is_south, hit, out_load;
  logic signed [TW:0]            t_diff;
  logic signed [TW-1:0]          t_hit;
  logic [tstv_pkg::AccW:0]       acc_sum;

  assign in_stall_o  = (state_q != ST_ACC);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    t_diff   = (TW+1)'(hit_time_i) - (TW+1)'(offs_q);
    t_hit    = tstv_pkg::sat_time((DW+1)'(t_diff));
    is_south = channel_i < CntW'(tstv_pkg::SideChannels);
    hit      = (charge_i > thr_q) &&
               ((is_south ? s_cnt_q : n_cnt_q) < CntW'(tstv_pkg::SideChannels));
    acc_sum  = {1'b0, acc_q} + (tstv_pkg::AccW+1)'(charge_i);
  end

  // read sequencing
  logic            issue;
  logic [CntW-1:0] m_cnt;
  logic [tstv_pkg::AddrW-1:0] raddr;

  always_comb begin
    m_cnt = (s_cnt_q > n_cnt_q) ? s_cnt_q : n_cnt_q;
    issue = !iss_done_q && (state_q == ST_MED || state_q == ST_WIN);
    if (state_q == ST_MED && !ph_q) begin
      raddr = j_q[tstv_pkg::AddrW-1:0];
    end else begin
      raddr = k_q[tstv_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hit && is_south) begin
      s_mem[s_cnt_q[tstv_pkg::AddrW-1:0]] <= t_hit;
    end
    if (in_acc && hit && !is_south) begin
      n_mem[n_cnt_q[tstv_pkg::AddrW-1:0]] <= t_hit;
    end
    s_rd_q <= s_mem[raddr];
    n_rd_q <= n_mem[raddr];
  end

  // median rank counting
  logic [CntW-1:0] lt_s_d, le_s_d, lt_n_d, le_n_d;
  logic [CntW-1:0] lo_s, hi_s, lo_n, hi_n;
  logic            s_own, n_own;

  always_comb begin
    s_own  = rd_idx_q < s_cnt_q;
    n_own  = rd_idx_q < n_cnt_q;
    lt_s_d = lt_s_q + CntW'(s_own && (s_rd_q < cand_s_q));
    le_s_d = le_s_q + CntW'(s_own && (s_rd_q <= cand_s_q));
    lt_n_d = lt_n_q + CntW'(n_own && (n_rd_q < cand_n_q));
    le_n_d = le_n_q + CntW'(n_own && (n_rd_q <= cand_n_q));
    lo_s   = (s_cnt_q - CntW'(1)) >> 1;
    hi_s   = s_cnt_q >> 1;
    lo_n   = (n_cnt_q - CntW'(1)) >> 1;
    hi_n   = n_cnt_q >> 1;
  end

  // window test
  logic signed [SW:0]   s_dev, n_dev;
  logic [SW:0]          s_abs, n_abs;
  logic [SW-1:0]        s_lim, n_lim;
  logic                 s_in_win, n_in_win;

  always_comb begin
    s_dev    = (SW+1)'(s_rd_q) * (SW+1)'($signed({1'b0, s_cnt_q})) - (SW+1)'(s_sum_q);
    n_dev    = (SW+1)'(n_rd_q) * (SW+1)'($signed({1'b0, n_cnt_q})) - (SW+1)'(n_sum_q);
    s_abs    = s_dev[SW] ? $unsigned(-s_dev) : $unsigned(s_dev);
    n_abs    = n_dev[SW] ? $unsigned(-n_dev) : $unsigned(n_dev);
    s_lim    = SW'(sigma_q) * SW'(s_cnt_q);
    n_lim    = SW'(sigma_q) * SW'(n_cnt_q);
    s_in_win = s_own && (s_abs < {1'b0, s_lim});
    n_in_win = n_own && (n_abs < {1'b0, n_lim});
  end

  // divider operand selection
  logic signed [DW-1:0] diff, nsel, a_val;
  logic [BW-1:0]        dsel, b_val;
  logic [DW-1:0]        mag;

  always_comb begin
    case (op_q)
      2'd0: begin
        diff = DW'(p1_q) - DW'(p2_q);
        nsel = (diff <<< 4) - diff;
        dsel = BW'(den1_q) << 4;
      end
      2'd1: begin
        diff = DW'(p1_q) + DW'(p2_q);
        nsel = diff;
        dsel = BW'(den1_q) << 1;
      end
      2'd2: begin
        diff = DW'(p3_q) - DW'(p4_q);
        nsel = (diff <<< 4) - diff;
        dsel = BW'(den2_q) << 4;
      end
      default: begin
        diff = DW'(p3_q) + DW'(p4_q);
        nsel = diff;
        dsel = BW'(den2_q) << 1;
      end
    endcase
    b_val = dsel << 1;
    a_val = (nsel <<< 1) + $signed(DW'(dsel));
    mag   = a_val[DW-1] ? $unsigned(-a_val + $signed(DW'(b_val)) - DW'(1)) : $unsigned(a_val);
  end

  logic [BW:0]          rem_sh;
  logic                 ge;
  logic [DW-1:0]        q_u;
  logic signed [DW-1:0] q_s;
  logic signed [DW:0]   q_ext, q_shift;

  always_comb begin
    rem_sh  = {rem_q, dq_q[DW-1]};
    ge      = rem_sh >= {1'b0, b_q};
    q_u     = {dq_q[DW-2:0], ge};
    q_s     = neg_q ? -$signed(q_u) : $signed(q_u);
    q_ext   = (DW+1)'(q_s);
    q_shift = q_ext + (DW+1)'(vshift_q);
  end

  // final values
  logic                       pair_ok, center_ok;
  logic signed [TW:0]         mn2, ms2;
  logic signed [TW+1:0]       md, msum;
  logic signed [TW+5:0]       v15;
  logic signed [TW+5:0]       vmed_r;
  logic signed [TW+1:0]       tmed_r;

  always_comb begin
    pair_ok   = (s_cnt_q >= CntW'(2)) && (n_cnt_q >= CntW'(2));
    center_ok = (s_cnt_q != '0) && (n_cnt_q != '0) && (s_cnt_q >= minh_q) &&
                (n_cnt_q >= minh_q) && (wcnt_s_q != '0) && (wcnt_n_q != '0);
    mn2       = (TW+1)'(vlo_n_q) + (TW+1)'(vhi_n_q);
    ms2       = (TW+1)'(vlo_s_q) + (TW+1)'(vhi_s_q);
    md        = (TW+2)'(mn2) - (TW+2)'(ms2);
    msum      = (TW+2)'(mn2) + (TW+2)'(ms2) + (TW+2)'(2);
    v15       = ((TW+6)'(md) <<< 4) - (TW+6)'(md);
    vmed_r    = (v15 + (TW+6)'(16)) >>> 5;
    tmed_r    = msum >>> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      thr_q       <= tstv_pkg::ChargeW'(102);
      offs_q      <= 16'sd3200;
      sigma_q     <= TW'(384);
      minh_q      <= CntW'(32);
      vshift_q    <= 16'sd456;
      s_sum_q     <= '0;
      n_sum_q     <= '0;
      s_cnt_q     <= '0;
      n_cnt_q     <= '0;
      acc_q       <= '0;
      iss_done_q  <= 1'b1;
      ph_q        <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      div_busy_q  <= 1'b0;
      op_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tstv_pkg::REG_THRESHOLD: thr_q    <= cfg_data_i;
          tstv_pkg::REG_OFFSET:    offs_q   <= signed'(cfg_data_i[TW-1:0]);
          tstv_pkg::REG_SIGMA:     sigma_q  <= cfg_data_i[TW-1:0];
          tstv_pkg::REG_MIN_HITS:  minh_q   <= cfg_data_i[CntW-1:0];
          tstv_pkg::REG_SHIFT:     vshift_q <= signed'(cfg_data_i[TW-1:0]);
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      rd_vld_q  <= issue;
      rd_cand_q <= (state_q == ST_MED) && !ph_q;
      rd_idx_q  <= (state_q == ST_MED && !ph_q) ? j_q : k_q;
      rd_end_q  <= k_q == m_cnt - CntW'(1);

      case (state_q)
        ST_ACC: begin
          if (in_acc) begin
            if (hit) begin
              if (is_south) begin
                s_sum_q <= s_sum_q + SW'(t_hit);
                s_cnt_q <= s_cnt_q + CntW'(1);
              end else begin
                n_sum_q <= n_sum_q + SW'(t_hit);
                n_cnt_q <= n_cnt_q + CntW'(1);
              end
              acc_q <= acc_sum[tstv_pkg::AccW] ? '1 : acc_sum[tstv_pkg::AccW-1:0];
            end
            if (last_i) begin
              state_q <= ST_START;
            end
          end
        end
        ST_START: begin
          j_q        <= '0;
          k_q        <= '0;
          ph_q       <= 1'b0;
          iss_done_q <= !pair_ok;
          state_q    <= ST_MED;
        end
        ST_MED: begin
          if (issue) begin
            if (!ph_q) begin
              ph_q <= 1'b1;
              k_q  <= '0;
            end else begin
              k_q <= k_q + CntW'(1);
              if (k_q == m_cnt - CntW'(1)) begin
                ph_q <= 1'b0;
                j_q  <= j_q + CntW'(1);
                if (j_q == m_cnt - CntW'(1)) begin
                  iss_done_q <= 1'b1;
                end
              end
            end
          end
          if (rd_vld_q) begin
            if (rd_cand_q) begin
              cand_s_q <= s_rd_q;
              cand_n_q <= n_rd_q;
              cand_j_q <= rd_idx_q;
              lt_s_q   <= '0;
              le_s_q   <= '0;
              lt_n_q   <= '0;
              le_n_q   <= '0;
            end else begin
              lt_s_q <= lt_s_d;
              le_s_q <= le_s_d;
              lt_n_q <= lt_n_d;
              le_n_q <= le_n_d;
              if (rd_end_q) begin
                if (cand_j_q < s_cnt_q && lt_s_d <= lo_s && lo_s < le_s_d) vlo_s_q <= cand_s_q;
                if (cand_j_q < s_cnt_q && lt_s_d <= hi_s && hi_s < le_s_d) vhi_s_q <= cand_s_q;
                if (cand_j_q < n_cnt_q && lt_n_d <= lo_n && lo_n < le_n_d) vlo_n_q <= cand_n_q;
                if (cand_j_q < n_cnt_q && lt_n_d <= hi_n && hi_n < le_n_d) vhi_n_q <= cand_n_q;
              end
            end
          end
          if (iss_done_q && !rd_vld_q) begin
            state_q    <= ST_WIN;
            k_q        <= '0;
            iss_done_q <= (m_cnt == '0);
            wsum_s_q   <= '0;
            wsum_n_q   <= '0;
            wcnt_s_q   <= '0;
            wcnt_n_q   <= '0;
          end
        end
        ST_WIN: begin
          if (issue) begin
            k_q <= k_q + CntW'(1);
            if (k_q == m_cnt - CntW'(1)) begin
              iss_done_q <= 1'b1;
            end
          end
          if (rd_vld_q) begin
            if (s_in_win) begin
              wsum_s_q <= wsum_s_q + SW'(s_rd_q);
              wcnt_s_q <= wcnt_s_q + CntW'(1);
            end
            if (n_in_win) begin
              wsum_n_q <= wsum_n_q + SW'(n_rd_q);
              wcnt_n_q <= wcnt_n_q + CntW'(1);
            end
          end
          if (iss_done_q && !rd_vld_q) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          p1_q       <= tstv_pkg::ProdW'(n_sum_q) *
                        tstv_pkg::ProdW'($signed({1'b0, s_cnt_q}));
          p2_q       <= tstv_pkg::ProdW'(s_sum_q) *
                        tstv_pkg::ProdW'($signed({1'b0, n_cnt_q}));
          p3_q       <= tstv_pkg::ProdW'(wsum_n_q) *
                        tstv_pkg::ProdW'($signed({1'b0, wcnt_s_q}));
          p4_q       <= tstv_pkg::ProdW'(wsum_s_q) *
                        tstv_pkg::ProdW'($signed({1'b0, wcnt_n_q}));
          den1_q     <= tstv_pkg::DenW'(n_cnt_q) * tstv_pkg::DenW'(s_cnt_q);
          den2_q     <= tstv_pkg::DenW'(wcnt_n_q) * tstv_pkg::DenW'(wcnt_s_q);
          op_q       <= '0;
          div_busy_q <= 1'b0;
          state_q    <= ST_DIV;
        end
        ST_DIV: begin
          if (!div_busy_q) begin
            dq_q       <= mag;
            neg_q      <= a_val[DW-1];
            b_q        <= b_val;
            rem_q      <= '0;
            div_cnt_q  <= '0;
            div_busy_q <= 1'b1;
          end else begin
            rem_q     <= ge ? BW'(rem_sh - {1'b0, b_q}) : BW'(rem_sh);
            dq_q      <= q_u;
            div_cnt_q <= div_cnt_q + tstv_pkg::DivCntW'(1);
            if (div_cnt_q == tstv_pkg::DivCntW'(DW - 1)) begin
              div_busy_q <= 1'b0;
              case (op_q)
                2'd0:    vm_q <= tstv_pkg::sat_vertex(q_shift);
                2'd1:    tm_q <= tstv_pkg::sat_time(q_ext);
                2'd2:    vc_q <= tstv_pkg::sat_vertex(q_shift);
                default: tc_q <= tstv_pkg::sat_time(q_ext);
              endcase
              if (op_q == 2'd3) begin
                state_q <= ST_OUT;
              end else begin
                op_q <= op_q + 2'd1;
              end
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            pair_q      <= pair_ok;
            o_vm_q      <= pair_ok ? vm_q : '0;
            o_tm_q      <= pair_ok ? tm_q : '0;
            o_vmed_q    <= pair_ok ? vmed_r[tstv_pkg::VertexW-1:0] : '0;
            o_tmed_q    <= pair_ok ? tmed_r[TW-1:0] : '0;
            center_q    <= center_ok;
            o_vc_q      <= center_ok ? vc_q : '0;
            o_tc_q      <= center_ok ? tc_q : '0;
            o_s_q       <= s_cnt_q;
            o_n_q       <= n_cnt_q;
            o_acc_q     <= acc_q;
            o_bin_q     <= tstv_pkg::centrality(acc_q);
            s_sum_q     <= '0;
            n_sum_q     <= '0;
            s_cnt_q     <= '0;
            n_cnt_q     <= '0;
            acc_q       <= '0;
            state_q     <= ST_ACC;
          end
        end
        default: state_q <= ST_ACC;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pair_valid_o        = pair_q;
  assign mean_vertex_o       = o_vm_q;
  assign event_time_mean_o   = o_tm_q;
  assign median_vertex_o     = o_vmed_q;
  assign event_time_median_o = o_tmed_q;
  assign center_valid_o      = center_q;
  assign vertex_by_center_o  = o_vc_q;
  assign event_time_center_o = o_tc_q;
  assign south_hits_o        = o_s_q;
  assign north_hits_o        = o_n_q;
  assign charge_total_o      = o_acc_q;
  assign cent_class_o        = o_bin_q;

  a_side_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_cnt_q <= CntW'(tstv_pkg::SideChannels)) && (n_cnt_q <= CntW'(tstv_pkg::SideChannels)))
    else $error("side hit count beyond side size");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i) |=> in_stall_o)
    else $error("input not stalled after last item");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result loaded outside output state");

  a_div_idle_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> (state_q == ST_DIV))
    else $error("divider busy outside divide state");

endmodule
